// ===== rtl/pstt_pkg.sv =====
package pstt_pkg;

	localparam int CW  = 32;          // coordinate width
	localparam int AW  = CW + 1;      // magnitude of a coordinate difference
	localparam int SW  = CW - 1;      // magnitude of a positive step
	localparam int SQW = 2 * AW;      // sum of squares
	localparam int NW  = SW + AW;     // step times difference
	localparam int RW  = SQW / 2;     // integer square root
	localparam int QW  = SW;          // per-axis move, never above the step

	typedef struct packed {
		logic signed [CW-1:0] src_x;
		logic signed [CW-1:0] src_y;
		logic signed [CW-1:0] dst_x;
		logic signed [CW-1:0] dst_y;
		logic signed [CW-1:0] step_len;
	} cmd_t;

	typedef struct packed {
		logic signed [CW-1:0] new_x;
		logic signed [CW-1:0] new_y;
		logic                 arrived;
		logic                 bad_step;
	} res_t;

	typedef struct packed {
		logic [CW-1:0] sx;
		logic [CW-1:0] sy;
		logic [CW-1:0] tx;
		logic [CW-1:0] ty;
		logic [AW-1:0] ax;
		logic [AW-1:0] ay;
		logic          nx;
		logic          ny;
		logic          bad;
		logic [SW-1:0] st;
	} item_t;

endpackage

// ===== rtl/pstt_front.sv =====
module pstt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  pstt_pkg::cmd_t   cmd,
	output logic             vld,
	output pstt_pkg::item_t  item
);

	logic             valid_s1;
	pstt_pkg::item_t  item_s1;
	pstt_pkg::item_t  item_d;
	logic [pstt_pkg::AW-1:0] dx, dy;

	always_comb begin
		dx = {cmd.dst_x[pstt_pkg::CW-1], cmd.dst_x} - {cmd.src_x[pstt_pkg::CW-1], cmd.src_x};
		dy = {cmd.dst_y[pstt_pkg::CW-1], cmd.dst_y} - {cmd.src_y[pstt_pkg::CW-1], cmd.src_y};
		item_d.sx  = cmd.src_x;
		item_d.sy  = cmd.src_y;
		item_d.tx  = cmd.dst_x;
		item_d.ty  = cmd.dst_y;
		item_d.nx  = dx[pstt_pkg::AW-1];
		item_d.ny  = dy[pstt_pkg::AW-1];
		item_d.ax  = dx[pstt_pkg::AW-1] ? -dx : dx;
		item_d.ay  = dy[pstt_pkg::AW-1] ? -dy : dy;
		// zero or negative step goes straight to the source
		item_d.bad = cmd.step_len[pstt_pkg::CW-1] || (cmd.step_len == '0);
		item_d.st  = cmd.step_len[pstt_pkg::SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

	assign vld  = valid_s1;
	assign item = item_s1;

endmodule

// ===== rtl/pstt_queue.sv =====
module pstt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pstt_pkg::item_t  wr_item,
	output logic             nonempty,
	output pstt_pkg::item_t  rd_item,
	output logic [2:0]       count
);

	pstt_pkg::item_t mem_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	// the back end takes the head every cycle it is there
	assign pop      = cnt_q != 3'd0;
	assign nonempty = pop;
	assign rd_item  = mem_q[rd_ptr_q];
	assign count    = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== rtl/pstt_back.sv =====
module pstt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld,
	input  pstt_pkg::item_t  item,
	output logic             done,
	output pstt_pkg::res_t   res
);

	localparam int CW  = pstt_pkg::CW;
	localparam int SQW = pstt_pkg::SQW;
	localparam int NW  = pstt_pkg::NW;
	localparam int RW  = pstt_pkg::RW;
	localparam int QW  = pstt_pkg::QW;

	typedef struct packed {
		logic [CW-1:0] bx;
		logic [CW-1:0] by;
		logic          nx;
		logic          ny;
		logic          move;
		logic          arrived;
		logic          bad;
	} ctx_t;

	typedef struct packed {
		logic [RW:0]    rem;
		logic [RW-1:0]  root;
		logic [SQW-1:0] dd;
		logic [NW-1:0]  nmx;
		logic [NW-1:0]  nmy;
		ctx_t           ctx;
	} sq_t;

	typedef struct packed {
		logic [RW-1:0] d;
		logic [RW-1:0] remx;
		logic [RW-1:0] remy;
		logic [QW-1:0] qx;
		logic [QW-1:0] qy;
		logic [NW-1:0] nmx;
		logic [NW-1:0] nmy;
		ctx_t          ctx;
	} dv_t;

	// products
	logic                 v_s1;
	logic [SQW-1:0]       sqx_s1, sqy_s1;
	logic [2*QW-1:0]      st2_s1;
	logic [NW-1:0]        nmx_s1, nmy_s1;
	pstt_pkg::item_t      it_s1;

	// distance test
	logic                 v_s2;
	sq_t                  sq_s2;

	logic                 sqv_s [RW+1];
	sq_t                  sqd_s [RW+1];
	logic                 dvv_s [QW+1];
	dv_t                  dvd_s [QW+1];

	logic                 done_q;
	pstt_pkg::res_t       res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= vld;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s1 <= item.ax * item.ax;
		sqy_s1 <= item.ay * item.ay;
		st2_s1 <= item.st * item.st;
		nmx_s1 <= item.st * item.ax;
		nmy_s1 <= item.st * item.ay;
		it_s1  <= item;
	end

	always_ff @(posedge clk) begin
		logic [SQW-1:0] dd;
		logic           arr;
		dd  = sqx_s1 + sqy_s1;
		arr = !it_s1.bad && (dd <= {{(SQW-2*QW){1'b0}}, st2_s1});
		sq_s2.rem         <= '0;
		sq_s2.root        <= '0;
		sq_s2.dd          <= dd;
		sq_s2.nmx         <= nmx_s1;
		sq_s2.nmy         <= nmy_s1;
		sq_s2.ctx.bx      <= arr ? it_s1.tx : it_s1.sx;
		sq_s2.ctx.by      <= arr ? it_s1.ty : it_s1.sy;
		sq_s2.ctx.nx      <= it_s1.nx;
		sq_s2.ctx.ny      <= it_s1.ny;
		sq_s2.ctx.move    <= !it_s1.bad && !arr;
		sq_s2.ctx.arrived <= arr;
		sq_s2.ctx.bad     <= it_s1.bad;
	end

	assign sqv_s[0] = v_s2;
	assign sqd_s[0] = sq_s2;

	// square root, one result bit per stage
	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [RW+2:0] cur, trial;
		logic          ge;
		sq_t           nxt;

		always_comb begin
			nxt   = sqd_s[j];
			cur   = {sqd_s[j].rem, sqd_s[j].dd[SQW-1-2*j -: 2]};
			trial = {1'b0, sqd_s[j].root, 2'b01};
			ge    = cur >= trial;
			nxt.rem  = ge ? (cur[RW:0] - trial[RW:0]) : cur[RW:0];
			nxt.root = {sqd_s[j].root[RW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[j+1] <= 1'b0;
			end else begin
				sqv_s[j+1] <= sqv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sqd_s[j+1] <= nxt;
		end
	end

	always_comb begin
		dvv_s[0]      = sqv_s[RW];
		dvd_s[0].d    = sqd_s[RW].root;
		dvd_s[0].remx = sqd_s[RW].nmx[NW-1 -: RW];
		dvd_s[0].remy = sqd_s[RW].nmy[NW-1 -: RW];
		dvd_s[0].qx   = '0;
		dvd_s[0].qy   = '0;
		dvd_s[0].nmx  = sqd_s[RW].nmx;
		dvd_s[0].nmy  = sqd_s[RW].nmy;
		dvd_s[0].ctx  = sqd_s[RW].ctx;
	end

	// both axes divided by the root, one quotient bit per stage
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [RW:0] curx, cury, dext;
		logic        gex, gey;
		dv_t         nxt;

		always_comb begin
			nxt  = dvd_s[j];
			dext = {1'b0, dvd_s[j].d};
			curx = {dvd_s[j].remx, dvd_s[j].nmx[QW-1-j]};
			cury = {dvd_s[j].remy, dvd_s[j].nmy[QW-1-j]};
			gex  = curx >= dext;
			gey  = cury >= dext;
			nxt.remx = gex ? (curx[RW-1:0] - dvd_s[j].d) : curx[RW-1:0];
			nxt.remy = gey ? (cury[RW-1:0] - dvd_s[j].d) : cury[RW-1:0];
			nxt.qx   = {dvd_s[j].qx[QW-2:0], gex};
			nxt.qy   = {dvd_s[j].qy[QW-2:0], gey};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[j+1] <= 1'b0;
			end else begin
				dvv_s[j+1] <= dvv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dvd_s[j+1] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dvv_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		logic [CW-1:0] qx, qy;
		ctx_t          c;
		c  = dvd_s[QW].ctx;
		qx = {1'b0, dvd_s[QW].qx};
		qy = {1'b0, dvd_s[QW].qy};
		res_q.new_x    <= !c.move ? c.bx : (c.nx ? c.bx - qx : c.bx + qx);
		res_q.new_y    <= !c.move ? c.by : (c.ny ? c.by - qy : c.by + qy);
		res_q.arrived  <= c.arrived;
		res_q.bad_step <= c.bad;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== rtl/point_step_toward_target_top.sv =====
// one command taken per cycle while busy is low, fully pipelined, up to one result per cycle
// done strobes once the command has passed from the front register, which loads on the edge
// that takes start, through the queue, two product and distance stages, 33 square root stages,
// 31 divide stages and the output register; the receiver cannot stall, so busy only rises if
// the queue would overflow
// arst_n clears every valid bit and the queue; payload registers are not reset
module point_step_toward_target_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  pstt_pkg::cmd_t  cmd,
	output logic            done,
	output pstt_pkg::res_t  res
);

	logic             take;
	logic             f_vld;
	pstt_pkg::item_t  f_item;
	logic             q_nonempty;
	pstt_pkg::item_t  q_item;
	logic [2:0]       q_count;

	// room for the queue contents plus the item held in the front stage
	assign busy = ({1'b0, q_count} + {3'b0, f_vld}) >= 4'd4;
	assign take = start && !busy;

	pstt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.cmd    (cmd),
		.vld    (f_vld),
		.item   (f_item)
	);

	pstt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_vld),
		.wr_item  (f_item),
		.nonempty (q_nonempty),
		.rd_item  (q_item),
		.count    (q_count)
	);

	pstt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (q_nonempty),
		.item   (q_item),
		.done   (done),
		.res    (res)
	);

endmodule

// ===== test/pstt_checker.sv =====
`timescale 1ns / 1ps

module pstt_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  pstt_pkg::cmd_t  cmd,
	input  logic            done,
	input  pstt_pkg::res_t  res,
	output int              fail_count,
	output int              pending,
	output int              moves_seen
);

	pstt_pkg::res_t move_q[$];

	// exact move toward the target, directions from the signs of the differences
	function automatic pstt_pkg::res_t step_point(pstt_pkg::cmd_t c);
		pstt_pkg::res_t r;
		logic signed [65:0] dx, dy;
		logic [65:0] ax, ay;
		logic [131:0] dd, ss, rt, t, qx, qy;
		r.arrived = 1'b0;
		r.bad_step = 1'b0;
		if (c.step_len <= 0) begin
			r.new_x = c.src_x;
			r.new_y = c.src_y;
			r.bad_step = 1'b1;
		end else begin
			dx = 66'(c.dst_x) - 66'(c.src_x);
			dy = 66'(c.dst_y) - 66'(c.src_y);
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			dd = 132'(ax) * 132'(ax) + 132'(ay) * 132'(ay);
			ss = 132'(c.step_len) * 132'(c.step_len);
			if (dd <= ss) begin
				r.new_x = c.dst_x;
				r.new_y = c.dst_y;
				r.arrived = 1'b1;
			end else begin
				rt = 0;
				for (int b = 65; b >= 0; b--) begin
					t = rt | (132'(1) << b);
					if (t * t <= dd)
						rt = t;
				end
				qx = (132'(c.step_len) * 132'(ax)) / rt;
				qy = (132'(c.step_len) * 132'(ay)) / rt;
				r.new_x = dx < 0 ? c.src_x - qx[31:0] : c.src_x + qx[31:0];
				r.new_y = dy < 0 ? c.src_y - qy[31:0] : c.src_y + qy[31:0];
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pstt_pkg::res_t want;
		int errs;
		if (!arst_n) begin
			move_q.delete();
			fail_count <= 0;
			moves_seen <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			if (start && !busy)
				move_q.push_back(step_point(cmd));
			if (done) begin
				moves_seen <= moves_seen + 1;
				if (move_q.size() == 0) begin
					$error("result with nothing expected");
					errs++;
				end else begin
					want = move_q.pop_front();
					if (res.new_x !== want.new_x) begin
						$error("new_x expected %0d actual %0d", want.new_x, res.new_x);
						errs++;
					end
					if (res.new_y !== want.new_y) begin
						$error("new_y expected %0d actual %0d", want.new_y, res.new_y);
						errs++;
					end
					if (res.arrived !== want.arrived) begin
						$error("arrived expected %0b actual %0b", want.arrived, res.arrived);
						errs++;
					end
					if (res.bad_step !== want.bad_step) begin
						$error("bad_step expected %0b actual %0b", want.bad_step,
							res.bad_step);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending <= move_q.size();
		end
	end

endmodule

// ===== test/tb_point_step_toward_target_top.sv =====
`timescale 1ns / 1ps

module tb_point_step_toward_target_top;

	localparam int LATENCY = 69;
	localparam int LIMIT = 200000;

	logic clk, arst_n, start, busy, done;
	pstt_pkg::cmd_t cmd;
	pstt_pkg::res_t res;
	int fail_count, pending, moves_seen;
	int cycles = 0;
	int sender_idle;

	point_step_toward_target_top dut (.*);

	pstt_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("run exceeded cycle limit");
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
		endcase
	endfunction

	// one transfer; the next command holds start high without a drop unless it draws an idle gap
	task automatic send(input pstt_pkg::cmd_t c);
		while ($urandom_range(0, 99) < sender_idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		// busy is settled mid-cycle, so the coming edge takes the command when it is low
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random();
		pstt_pkg::cmd_t c;
		c.src_x = rand_coord();
		c.src_y = rand_coord();
		case ($urandom_range(0, 9))
			0: begin c.dst_x = c.src_x; c.dst_y = rand_coord(); end
			1: begin c.dst_y = c.src_y; c.dst_x = rand_coord(); end
			2: begin
				c.dst_x = c.src_x + $signed($urandom_range(0, 2000)) - 1000;
				c.dst_y = c.src_y + $signed($urandom_range(0, 2000)) - 1000;
			end
			default: begin c.dst_x = rand_coord(); c.dst_y = rand_coord(); end
		endcase
		case ($urandom_range(0, 9))
			0: c.step_len = -$signed($urandom_range(0, 3));
			1: c.step_len = $urandom;
			2: c.step_len = 32'sh7fffffff;
			3: c.step_len = $urandom_range(1, 1500);
			default: c.step_len = $urandom_range(1, 32'h00ffffff);
		endcase
		send(c);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		sender_idle = 30;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, both bad step signs, zero distance, axis moves, exact arrival
		send('{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh00010000});
		send('{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff});
		send('{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1});
		send('{1, 2, 3, 4, 0});
		send('{1, 2, 3, 4, 32'sh80000000});
		send('{1, 2, 3, 4, -1});
		send('{5, 5, 5, 5, 1});
		send('{0, 0, 0, 32'sh00050000, 32'sh00010000});
		send('{0, 0, 0, -32'sh00050000, 32'sh00010000});
		send('{0, 0, 32'sh00050000, 0, 32'sh00010000});
		send('{0, 0, -32'sh00050000, 0, 32'sh00010000});
		send('{0, 0, 3, 4, 5});
		send('{0, 0, 3, 4, 4});
		send('{0, 0, -3, -4, 6});
		send('{-10, 7, 20, -33, 3});

		for (int i = 0; i < 1600; i++) begin
			if (i == 530) sender_idle = 51;
			if (i == 1060) sender_idle = 0;
			send_random();
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("%0d moves checked: bad steps, arrivals, axis and diagonal moves", moves_seen);
		$display("sender gaps at 30%% and 51%% then back to back");
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/pstt_pkg.sv
rtl/pstt_front.sv
rtl/pstt_queue.sv
rtl/pstt_back.sv
rtl/point_step_toward_target_top.sv
test/pstt_checker.sv
test/tb_point_step_toward_target_top.sv
